/* rtl/core/rsti_pkg.sv */
// Shared types and constants for the radix string to integer converter.
// Used by the front end, the item queue, the accumulator back end and the top level.
package rsti_pkg;

  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_QUEUE_DEPTH = 4;
  localparam int OUT_BITS        = 32;
  localparam int CALC_BITS       = 64;
  localparam int RADIX_BITS      = 6;
  localparam int CHAR_BITS       = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] LETTER_BASE = RADIX_BITS'(10);

  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_DIGIT = 2'd0,
    K_MINUS = 2'd1,
    K_BAD   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [RADIX_BITS-1:0] digit;
    logic [RADIX_BITS-1:0] radix;
    logic                  last;
  } char_item_t;

endpackage

/* rtl/core/radix_string_to_integer.sv */
// Top level of the radix string to integer converter.
// Instantiates rsti_front, rsti_queue and rsti_back; depends on rsti_pkg.
//
//   Channel   Handshake                Payload
//   in_       in_push / in_full        in_char_code[7:0], in_last_char
//   out_      out_pop / out_empty      out_value[31:0] (signed), out_status[1:0]
//   cfg_      cfg_valid / cfg_ready    cfg_radix[5:0]
//
// One character beat is taken per cycle while in_full is low, and its classification
// enters the queue in that cycle. Unless a stall holds it, the back end retires one queued
// character per cycle with a single multiply-add by the radix. Only a last character stalls
// in the back end while an earlier result is still waiting. A result is on the out_ ports
// from the edge that takes its last character from the queue; the result is registered.
// in_full is high while QUEUE_DEPTH beats wait. Reset is synchronous; cfg_ready is always high.
module radix_string_to_integer import rsti_pkg::*; #(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [CHAR_BITS-1:0]  in_char_code,
  input  logic                  in_last_char,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [OUT_BITS-1:0] out_value,
  output logic [1:0]            out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RADIX_BITS-1:0] cfg_radix
);

  char_item_t front_item;
  char_item_t q_item;
  logic       q_valid;
  logic       q_take;
  logic [OUT_BITS-1:0] res_value;

  assign cfg_ready = 1'b1;
  assign out_value = res_value;

  rsti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_radix),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .item      (front_item)
  );

  rsti_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_push),
    .wr_item  (front_item),
    .full     (in_full),
    .rd_en    (q_take),
    .rd_item  (q_item),
    .rd_valid (q_valid)
  );

  rsti_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item       (q_item),
    .item_take  (q_take),
    .res_empty  (out_empty),
    .res_pop    (out_pop),
    .res_value  (res_value),
    .res_status (out_status)
  );

endmodule

/* rtl/core/rsti_front.sv */
// Front end: holds the radix register and classifies each incoming character.
// Depends on rsti_pkg for the character constants and the item type.
module rsti_front import rsti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [RADIX_BITS-1:0] cfg_data,
  input  logic [CHAR_BITS-1:0]  char_code,
  input  logic                  last_char,
  output char_item_t            item
);

  logic [RADIX_BITS-1:0] radix_r;
  logic [RADIX_BITS-1:0] radix_nxt;
  logic [RADIX_BITS-1:0] eff_radix;
  logic [CHAR_BITS-1:0]  offs;
  logic                  is_char;

  always_comb begin
    radix_nxt = cfg_we ? cfg_data : radix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_r;
    end
  end

  always_comb begin
    is_char = 1'b1;
    offs    = '0;
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      offs = char_code - CH_ZERO;
    end else if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
      offs = char_code - CH_UP_A + CHAR_BITS'(LETTER_BASE);
    end else if (char_code >= CH_LO_A && char_code <= CH_LO_Z) begin
      offs = char_code - CH_LO_A + CHAR_BITS'(LETTER_BASE);
    end else begin
      is_char = 1'b0;
    end

    item.digit = offs[RADIX_BITS-1:0];
    item.radix = eff_radix;
    item.last  = last_char;
    if (char_code == CH_MINUS) begin
      item.kind = K_MINUS;
    end else if (is_char && offs[RADIX_BITS-1:0] < eff_radix) begin
      item.kind = K_DIGIT;
    end else begin
      item.kind = K_BAD;
    end
  end

endmodule

/* rtl/core/rsti_queue.sv */
// Short queue of classified characters between the front end and the back end.
// Depends on rsti_pkg for the item type.
module rsti_queue import rsti_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  char_item_t wr_item,
  output logic       full,
  input  logic       rd_en,
  output char_item_t rd_item,
  output logic       rd_valid
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  char_item_t          mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_wr;
  logic                do_rd;

  assign full     = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_BITS'(do_wr) - CNT_BITS'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* rtl/core/rsti_back.sv */
// Back end: magnitude accumulator with overflow check and the result register.
// Depends on rsti_pkg for the item type and status codes.
module rsti_back import rsti_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  char_item_t          item,
  output logic                item_take,
  output logic                res_empty,
  input  logic                res_pop,
  output logic [OUT_BITS-1:0] res_value,
  output logic [1:0]          res_status
);

  localparam int MAG_W  = VALUE_BITS - 1;
  localparam int PROD_W = MAG_W + RADIX_BITS + 1;

  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                first_r, first_nxt;
  status_t             err_r, err_nxt;
  logic                have_r, have_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [OUT_BITS-1:0] rvalue_r, rvalue_nxt;
  status_t             rstat_r, rstat_nxt;

  logic [PROD_W-1:0]    sum;
  logic                 ovf;
  status_t              final_err;
  logic [CALC_BITS-1:0] wide;
  logic [CALC_BITS-1:0] signed_val;

  assign item_take  = item_valid && (!item.last || !rvalid_r || res_pop);
  assign res_empty  = !rvalid_r;
  assign res_value  = rvalue_r;
  assign res_status = rstat_r;

  assign sum = PROD_W'(mag_r) * PROD_W'(item.radix) + PROD_W'(item.digit);
  assign ovf = (sum[PROD_W-1:MAG_W] != '0);

  always_comb begin
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    first_nxt  = first_r;
    err_nxt    = err_r;
    have_nxt   = have_r;
    rvalid_nxt = rvalid_r && !res_pop;
    rvalue_nxt = rvalue_r;
    rstat_nxt  = rstat_r;
    final_err  = ST_OK;
    wide       = '0;
    signed_val = '0;

    if (item_take) begin
      first_nxt = 1'b0;
      if (err_r == ST_OK) begin
        case (item.kind)
          K_MINUS: begin
            if (first_r) begin
              neg_nxt = 1'b1;
            end else begin
              err_nxt = ST_BAD;
            end
          end
          K_DIGIT: begin
            if (ovf) begin
              err_nxt = ST_OVF;
            end else begin
              mag_nxt  = sum[MAG_W-1:0];
              have_nxt = 1'b1;
            end
          end
          default: begin
            err_nxt = ST_BAD;
          end
        endcase
      end

      if (item.last) begin
        final_err  = (err_nxt == ST_OK && !have_nxt) ? ST_BAD : err_nxt;
        wide       = CALC_BITS'(mag_nxt);
        signed_val = neg_nxt ? (CALC_BITS'(0) - wide) : wide;
        rvalid_nxt = 1'b1;
        rstat_nxt  = final_err;
        rvalue_nxt = (final_err == ST_OK) ? signed_val[OUT_BITS-1:0] : '0;
        mag_nxt    = '0;
        neg_nxt    = 1'b0;
        first_nxt  = 1'b1;
        err_nxt    = ST_OK;
        have_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r    <= '0;
      neg_r    <= 1'b0;
      first_r  <= 1'b1;
      err_r    <= ST_OK;
      have_r   <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      first_r  <= first_nxt;
      err_r    <= err_nxt;
      have_r   <= have_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rvalue_r <= rvalue_nxt;
    rstat_r  <= rstat_nxt;
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the radix string to integer converter.
// Depends on rsti_pkg and radix_string_to_integer; predicts each token result and
// checks it beat by beat under random input gaps, output stalls and radix changes.
module tb_top import rsti_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VALUE_LIMIT   = 64'h7FFF_FFFF;
  localparam logic [63:0] NOT_A_DIGIT   = 64'd99;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          LONG_HOLD     = 300;

  typedef struct {
    logic signed [OUT_BITS-1:0] value;
    status_t                    status;
  } conv_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [CHAR_BITS-1:0]       in_char_code = '0;
  logic                       in_last_char = 1'b0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic signed [OUT_BITS-1:0] out_value;
  logic [1:0]                 out_status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [RADIX_BITS-1:0]      cfg_radix = '0;

  logic [63:0]           tok_mag = '0;
  logic                  tok_neg = 1'b0;
  logic                  tok_first = 1'b1;
  logic                  tok_has_digit = 1'b0;
  status_t               tok_err = ST_OK;
  logic [RADIX_BITS-1:0] radix_reg = RADIX_RESET;

  conv_result_t expected_results[$];
  conv_result_t want_result;
  int           mismatch_count = 0;
  int           results_checked = 0;
  int           chars_sent = 0;
  int           tokens_sent = 0;
  int           radix_settings = 1;
  int           idle_cycles = 0;
  int           rx_stall = 0;
  int           rx_hold_req = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;

  radix_string_to_integer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_char_code(in_char_code),
    .in_last_char(in_last_char),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_value   (out_value),
    .out_status  (out_status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_radix   (cfg_radix)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(input bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] base_of(input logic [RADIX_BITS-1:0] r);
    if (r < RADIX_MIN) return 64'(RADIX_MIN);
    if (r > RADIX_MAX) return 64'(RADIX_MAX);
    return 64'(r);
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [63:0] d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
  endfunction

  task automatic predict_char(input logic [CHAR_BITS-1:0] ch, input logic last);
    logic [63:0]  d;
    logic [63:0]  r;
    conv_result_t res;
    if (tok_err == ST_OK) begin
      if (ch == CH_MINUS) begin
        if (tok_first) tok_neg = 1'b1;
        else tok_err = ST_BAD;
      end else begin
        d = NOT_A_DIGIT;
        if (ch >= CH_ZERO && ch <= CH_NINE) d = 64'(ch - CH_ZERO);
        else if (ch >= CH_UP_A && ch <= CH_UP_Z) d = 64'(ch - CH_UP_A) + 10;
        else if (ch >= CH_LO_A && ch <= CH_LO_Z) d = 64'(ch - CH_LO_A) + 10;
        r = base_of(radix_reg);
        if (d >= r) tok_err = ST_BAD;
        else if (tok_mag > (VALUE_LIMIT - d) / r) tok_err = ST_OVF;
        else begin
          tok_mag = tok_mag * r + d;
          tok_has_digit = 1'b1;
        end
      end
    end
    tok_first = 1'b0;
    if (last) begin
      if (tok_err == ST_OK && !tok_has_digit) tok_err = ST_BAD;
      res.value = '0;
      if (tok_err == ST_OK) res.value = tok_neg ? 32'd0 - tok_mag[31:0] : tok_mag[31:0];
      res.status = tok_err;
      expected_results.push_back(res);
      tok_mag = '0;
      tok_neg = 1'b0;
      tok_first = 1'b1;
      tok_has_digit = 1'b0;
      tok_err = ST_OK;
    end
  endtask

  task automatic send_char(input logic [CHAR_BITS-1:0] ch, input logic last);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_char_code <= ch;
    in_last_char <= last;
    do @(posedge clk); while (in_full);
    predict_char(ch, last);
    chars_sent++;
    if (last) tokens_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_number(input logic [63:0] mag, input bit neg);
    logic [CHAR_BITS-1:0] digits[$];
    logic [63:0]          r;
    logic [63:0]          m;
    r = base_of(radix_reg);
    m = mag;
    do begin
      digits.push_front(digit_char(m % r));
      m = m / r;
    end while (m != 0);
    if (neg) digits.push_front(CH_MINUS);
    foreach (digits[i]) send_char(digits[i], i == digits.size() - 1);
  endtask

  task automatic send_noise_token();
    int                   len;
    logic [CHAR_BITS-1:0] ch;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: ch = 8'($urandom_range(0, 255));
        1: ch = CH_MINUS;
        2: ch = digit_char(64'($urandom_range(0, 32'(base_of(radix_reg)) - 1)));
        default: ch = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A);
      endcase
      send_char(ch, i == len - 1);
    end
  endtask

  task automatic send_random_token();
    logic [63:0] mag;
    if ($urandom_range(0, 9) < 3) begin
      send_noise_token();
    end else begin
      case ($urandom_range(0, 5))
        0, 1: mag = 64'($urandom_range(0, 999));
        2: mag = 64'($urandom_range(0, 65535));
        3: mag = 64'($urandom);
        4: mag = VALUE_LIMIT - 64'($urandom_range(0, 2));
        default: mag = VALUE_LIMIT + 64'd1 + 64'($urandom_range(0, 1));
      endcase
      send_number(mag, $urandom_range(0, 9) < 3);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [RADIX_BITS-1:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_reg = r;
    radix_settings++;
  endtask

  task automatic test_signs_and_symbols();
    send_text("7");
    send_text("-");
    send_text("5-Z");
    send_text("-0");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_radix_extremes();
    cfg_write(RADIX_MAX);
    send_text("zZ");
    send_number(VALUE_LIMIT, 1'b1);
    send_number(VALUE_LIMIT + 64'd1, 1'b0);
    cfg_write(RADIX_MIN);
    send_text("12");
    cfg_write(6'h3F);
    send_text("z");
  endtask

  task automatic test_random_tokens(input logic [RADIX_BITS-1:0] r, input int count);
    int start;
    cfg_write(r);
    start = chars_sent;
    while (chars_sent - start < count) send_random_token();
  endtask

  task automatic test_output_stall();
    rx_hold_req = LONG_HOLD;
    tx_quiet = 1'b1;
    for (int i = 0; i < 24; i++) send_char(digit_char(64'($urandom_range(0, 9))), 1'b1);
    tx_quiet = 1'b0;
  endtask

  task automatic test_back_to_back();
    int start;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    start = chars_sent;
    while (chars_sent - start < 40) send_random_token();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, value %0d status %0d", $time, out_value,
                   out_status);
          mismatch_count++;
        end else begin
          want_result = expected_results.pop_front();
          if (out_value !== want_result.value) begin
            $display("%0t: value mismatch, expected %0d, got %0d", $time,
                     want_result.value, out_value);
            mismatch_count++;
          end
          if (out_status !== 2'(want_result.status)) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time,
                     want_result.status, out_status);
            mismatch_count++;
          end
          results_checked++;
        end
      end
      if (rx_hold_req > 0) begin
        rx_stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_stall > 0) rx_stall--;
      else rx_stall = pick_gap(rx_quiet);
      out_pop <= (rx_stall == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signs_and_symbols();
    test_radix_extremes();
    test_random_tokens(6'd10, 40);
    test_random_tokens(RADIX_MIN, 30);
    test_random_tokens(6'd16, 40);
    test_random_tokens(RADIX_MAX, 40);
    test_output_stall();
    test_random_tokens(6'd0, 30);
    test_random_tokens(6'd1, 20);
    test_random_tokens(6'd37, 30);
    test_back_to_back();
    test_random_tokens(6'($urandom_range(3, 35)), 40);
    test_random_tokens(6'd8, 30);
    drain();
    $display("Checked %0d results from %0d tokens (%0d characters) over %0d radix settings,",
             results_checked, tokens_sent, chars_sent, radix_settings);
    $display("with random gaps, back-to-back beats and a long output stall.");
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
